FILE: design/hrc_pkg.sv
// shared types and constants for the hermite rise curve generator
// no dependencies; imported by every module of the block

package hrc_pkg;

    // field widths
    localparam int TIME_W  = 24;
    localparam int AMP_W   = 16;
    localparam int SPR_W   = 16;
    localparam int TAN_W   = 16;
    localparam int SUB_W   = 4;
    localparam int LEVEL_W = 24;
    localparam int CFG_W   = 24;
    localparam int ADDR_W  = 3;

    // internal arithmetic widths
    localparam int NUM_W  = 32;   // signed curve position numerator
    localparam int DEN_W  = 23;   // 6 * spread * substeps
    localparam int Q_W    = 16;   // curve position, Q0.16
    localparam int MUL_AW = 35;   // shared multiplier operand a, signed
    localparam int MUL_BW = 19;   // shared multiplier operand b, signed
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int ACC_W  = 51;   // Q44 polynomial accumulator

    // configuration register indexes
    localparam logic [ADDR_W-1:0] CFG_AMPLITUDE     = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_MIDPOINT_TIME = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_SPREAD        = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_START_TANGENT = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_END_TANGENT   = 3'd4;
    localparam logic [ADDR_W-1:0] CFG_SUBSTEPS      = 3'd5;

    // bit positions in the result tuser
    localparam int USER_RISE      = 0;
    localparam int USER_CURVE_END = 1;
    localparam int USER_W         = 2;

    // curve shape coefficients handed to the evaluator
    typedef struct packed {
        logic        [AMP_W-1:0] amplitude;
        logic signed [TAN_W-1:0] start_tangent;
        logic signed [TAN_W-1:0] end_tangent;
    } hrc_coef_t;

endpackage

FILE: design/hrc_mul.sv
// shared signed multiplier with registered product
// depends on hrc_pkg for operand widths

module hrc_mul import hrc_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_AW-1:0] a,
    input  logic signed [MUL_BW-1:0] b,
    output logic signed [MUL_PW-1:0] p
);

    logic signed [MUL_PW-1:0] p_reg;

    // one product per cycle, product registered
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

FILE: design/hrc_div.sv
// radix-2 restoring divider giving floor(num * 2^16 / den) for 0 < num < den
// depends on hrc_pkg for widths; one quotient bit per cycle

module hrc_div import hrc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DEN_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   q
);

    logic             busy_reg;
    logic             done_reg;
    logic [3:0]       cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   q_reg;
    logic [DEN_W:0]   rem_dbl;
    logic             fits;

    // shifted remainder against the divisor
    assign rem_dbl = {rem_reg, 1'b0};
    assign fits    = (rem_dbl >= {1'b0, den});

    // iteration control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= num;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= DEN_W'(rem_dbl - {1'b0, den});
                end
                else
                begin
                    rem_reg <= rem_dbl[DEN_W-1:0];
                end
                q_reg   <= {q_reg[Q_W-2:0], fits};
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(Q_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

FILE: design/hrc_curve.sv
// cubic hermite polynomial evaluator sequencing one shared multiplier
// depends on hrc_pkg and hrc_mul; steps through the states C_OP1 to C_FIN from start to done

module hrc_curve import hrc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [Q_W-1:0]            q,
    input  hrc_coef_t                 coef,
    output logic                      done,
    output logic signed [LEVEL_W-1:0] level
);

    typedef enum logic [3:0] {
        C_IDLE,
        C_OP1,
        C_OP2,
        C_OP3,
        C_OP4,
        C_OP5,
        C_OP6,
        C_OP7,
        C_ACC,
        C_OP8,
        C_FIN
    } cstate_t;

    cstate_t                    state_reg;
    logic [Q_W-1:0]             q_reg;
    logic [Q_W-1:0]             s2_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [LEVEL_W-1:0]  level_reg;
    logic                       done_reg;

    logic signed [MUL_AW-1:0]   mul_a;
    logic signed [MUL_BW-1:0]   mul_b;
    logic signed [MUL_PW-1:0]   mul_p;
    logic signed [17:0]         m;
    logic signed [29:0]         lvl_wide;

    // m = q - 1.0, always negative
    assign m        = $signed({2'b11, q_reg});
    assign lvl_wide = mul_p[MUL_PW-1:24];

    hrc_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // operand selection per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            C_OP1:
            begin
                mul_a = {19'b0, q_reg};
                mul_b = {3'b0, q_reg};
            end
            C_OP2:
            begin
                mul_a = {{17{m[17]}}, m};
                mul_b = {m[17], m};
            end
            C_OP3:
            begin
                mul_a = mul_p[MUL_AW-1:0];
                mul_b = {3'b0, q_reg};
            end
            C_OP4:
            begin
                mul_a = mul_p[50:16];
                mul_b = {{3{coef.start_tangent[TAN_W-1]}}, coef.start_tangent};
            end
            C_OP5:
            begin
                mul_a = {19'b0, s2_reg};
                mul_b = 19'h30000 - {2'b00, q_reg, 1'b0};
            end
            C_OP6:
            begin
                mul_a = {19'b0, s2_reg};
                mul_b = {m[17], m};
            end
            C_OP7:
            begin
                mul_a = mul_p[MUL_AW-1:0];
                mul_b = {{3{coef.end_tangent[TAN_W-1]}}, coef.end_tangent};
            end
            C_OP8:
            begin
                mul_a = acc_reg[ACC_W-1:16];
                mul_b = {3'b0, coef.amplitude};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            q_reg     <= '0;
            s2_reg    <= '0;
            acc_reg   <= '0;
            level_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        q_reg     <= q;
                        state_reg <= C_OP1;
                    end
                end
                C_OP1:
                begin
                    state_reg <= C_OP2;
                end
                C_OP2:
                begin
                    // q squared, back to Q0.16
                    s2_reg    <= mul_p[31:16];
                    state_reg <= C_OP3;
                end
                C_OP3:
                begin
                    state_reg <= C_OP4;
                end
                C_OP4:
                begin
                    state_reg <= C_OP5;
                end
                C_OP5:
                begin
                    // start tangent term
                    acc_reg   <= mul_p[ACC_W-1:0];
                    state_reg <= C_OP6;
                end
                C_OP6:
                begin
                    // smoothstep term in Q44
                    acc_reg   <= acc_reg + {mul_p[38:0], 12'b0};
                    state_reg <= C_OP7;
                end
                C_OP7:
                begin
                    state_reg <= C_ACC;
                end
                C_ACC:
                begin
                    // end tangent term
                    acc_reg   <= acc_reg + mul_p[ACC_W-1:0];
                    state_reg <= C_OP8;
                end
                C_OP8:
                begin
                    state_reg <= C_FIN;
                end
                C_FIN:
                begin
                    // scale by amplitude and saturate
                    if (lvl_wide > 30'sd8388607)
                    begin
                        level_reg <= 24'sh7FFFFF;
                    end
                    else if (lvl_wide < -30'sd8388608)
                    begin
                        level_reg <= 24'sh800000;
                    end
                    else
                    begin
                        level_reg <= lvl_wide[LEVEL_W-1:0];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign level = level_reg;

endmodule

FILE: design/hermite_rise_curve_generator_core.sv
// per frame: a set-up state, then per result the eval and load states on held or
// plateau samples, or also the divider (one quotient bit a cycle) and the shared
// multiplier steps on the rise; one frame at a time; the next frame is taken while
// the last result of a frame still waits in the output register; reset is
// asynchronous, active low, clears the curve state and output and returns the
// configuration registers to their defaults

module hermite_rise_curve_generator_core import hrc_pkg::*;
#(
    parameter int MAX_SUBSTEPS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration writes
    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    // frame input
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TIME_W-1:0]   s_tdata,   // [23:0] frame_time
    input  logic                s_tlast,   // last_frame
    // result output
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [LEVEL_W-1:0]  m_tdata,   // [23:0] level
    output logic [USER_W-1:0]   m_tuser,   // [0] rise_frame, [1] curve_end
    output logic                m_tlast    // last_substep
);

    localparam int SUB_CAP = (MAX_SUBSTEPS > 15) ? 15 : MAX_SUBSTEPS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EVAL,
        ST_DIV,
        ST_CURVE,
        ST_LOAD
    } state_t;

    // configuration registers
    logic [AMP_W-1:0]         amp_reg;
    logic [TIME_W-1:0]        mid_reg;
    logic [SPR_W-1:0]         spread_reg;
    logic signed [TAN_W-1:0]  st_tan_reg;
    logic signed [TAN_W-1:0]  end_tan_reg;
    logic [SUB_W-1:0]         sub_reg;

    // curve state and sequencer
    state_t                   state_reg;
    logic [TIME_W-1:0]        prev_reg;
    logic signed [LEVEL_W-1:0] held_reg;
    logic                     rdone_reg;
    logic                     rseen_reg;
    logic [TIME_W-1:0]        t_reg;
    logic                     last_reg;
    logic [SUB_W-1:0]         s_reg;
    logic [SUB_W-1:0]         k_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic signed [25:0]       step_reg;
    logic [DEN_W-1:0]         d_reg;
    logic                     rise_reg;
    logic                     dset_reg;
    logic signed [LEVEL_W-1:0] lvl_reg;

    // output register
    logic                     m_tvalid_reg;
    logic [LEVEL_W-1:0]       m_tdata_reg;
    logic [USER_W-1:0]        m_tuser_reg;
    logic                     m_tlast_reg;

    logic [SUB_W-1:0]         sub_nz;
    logic [SUB_W-1:0]         s_eff;
    logic [SPR_W-1:0]         sp;
    logic [17:0]              sp3;
    logic [18:0]              sp6;
    logic signed [24:0]       diff_pm;
    logic signed [24:0]       diff_tp;
    logic signed [24:0]       diff_tm;
    logic signed [26:0]       base;
    logic signed [26:0]       end_val;
    logic signed [NUM_W-1:0]  num0;
    logic [19:0]              sp_s;
    logic [DEN_W-1:0]         d_val;
    logic signed [LEVEL_W-1:0] plateau;
    logic                     num_ge_d;
    logic                     num_pos;
    logic                     last_sub;
    logic                     out_free;

    logic                     div_start;
    logic                     div_done;
    logic [Q_W-1:0]           div_q;
    logic                     curve_start;
    logic                     curve_done;
    logic signed [LEVEL_W-1:0] curve_level;
    hrc_coef_t                coef;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg     <= '0;
            mid_reg     <= '0;
            spread_reg  <= 16'd256;
            st_tan_reg  <= '0;
            end_tan_reg <= '0;
            sub_reg     <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_AMPLITUDE:     amp_reg     <= cfg_wdata[AMP_W-1:0];
                CFG_MIDPOINT_TIME: mid_reg     <= cfg_wdata[TIME_W-1:0];
                CFG_SPREAD:        spread_reg  <= cfg_wdata[SPR_W-1:0];
                CFG_START_TANGENT: st_tan_reg  <= cfg_wdata[TAN_W-1:0];
                CFG_END_TANGENT:   end_tan_reg <= cfg_wdata[TAN_W-1:0];
                CFG_SUBSTEPS:      sub_reg     <= cfg_wdata[SUB_W-1:0];
                default:           ;
            endcase
        end
    end

    // substep count clamped to one..cap, spread never zero
    assign sub_nz = (sub_reg == '0) ? 4'd1 : sub_reg;
    assign s_eff  = (32'(sub_nz) > SUB_CAP) ? SUB_W'(SUB_CAP) : sub_nz;
    assign sp     = (spread_reg == '0) ? 16'd1 : spread_reg;
    assign sp3    = {1'b0, sp, 1'b0} + {2'b0, sp};
    assign sp6    = {1'b0, sp, 2'b0} + {2'b0, sp, 1'b0};

    // frame set-up terms: numerator at the previous time, per-substep step, divisor
    assign diff_pm = $signed({1'b0, prev_reg}) - $signed({1'b0, mid_reg});
    assign diff_tp = $signed({1'b0, t_reg}) - $signed({1'b0, prev_reg});
    assign diff_tm = $signed({1'b0, t_reg}) - $signed({1'b0, mid_reg});
    assign base    = $signed({diff_pm[24], diff_pm, 1'b0}) + $signed({9'b0, sp3});
    assign end_val = $signed({diff_tm[24], diff_tm, 1'b0}) + $signed({9'b0, sp3});
    assign num0    = $signed({{5{base[26]}}, base}) * $signed({28'b0, s_reg});
    assign sp_s    = {4'b0, sp} * {16'b0, s_reg};
    assign d_val   = {1'b0, sp_s, 2'b0} + {2'b0, sp_s, 1'b0};

    assign plateau  = {4'b0, amp_reg, 4'b0};
    assign num_ge_d = (num_reg >= $signed({9'b0, d_reg}));
    assign num_pos  = !num_reg[NUM_W-1] && (num_reg != '0);
    assign last_sub = (k_reg == s_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    assign div_start   = (state_reg == ST_EVAL) && !rdone_reg && !num_ge_d && num_pos;
    assign curve_start = (state_reg == ST_DIV) && div_done;

    assign coef.amplitude     = amp_reg;
    assign coef.start_tangent = st_tan_reg;
    assign coef.end_tangent   = end_tan_reg;

    hrc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg[DEN_W-1:0]),
        .den   (d_reg),
        .done  (div_done),
        .q     (div_q)
    );

    hrc_curve u_curve (
        .clk   (clk),
        .rst_n (rst_n),
        .start (curve_start),
        .q     (div_q),
        .coef  (coef),
        .done  (curve_done),
        .level (curve_level)
    );

    // frame sequencer, curve state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            prev_reg     <= '0;
            held_reg     <= '0;
            rdone_reg    <= 1'b0;
            rseen_reg    <= 1'b0;
            t_reg        <= '0;
            last_reg     <= 1'b0;
            s_reg        <= 4'd1;
            k_reg        <= 4'd1;
            num_reg      <= '0;
            step_reg     <= '0;
            d_reg        <= '0;
            rise_reg     <= 1'b0;
            dset_reg     <= 1'b0;
            lvl_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        t_reg     <= s_tdata;
                        last_reg  <= s_tlast;
                        s_reg     <= s_eff;
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    // the frame's last sample decides the rise flags up front
                    num_reg   <= num0 + {{6{diff_tp[24]}}, diff_tp, 1'b0};
                    step_reg  <= {diff_tp, 1'b0};
                    d_reg     <= d_val;
                    rise_reg  <= !rdone_reg && !rseen_reg && (end_val > 27'sd0);
                    dset_reg  <= (end_val >= $signed({8'b0, sp6}));
                    k_reg     <= 4'd1;
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    if (rdone_reg)
                    begin
                        lvl_reg   <= plateau;
                        state_reg <= ST_LOAD;
                    end
                    else if (num_ge_d)
                    begin
                        lvl_reg   <= plateau;
                        held_reg  <= plateau;
                        state_reg <= ST_LOAD;
                    end
                    else if (num_pos)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        lvl_reg   <= held_reg;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_CURVE;
                    end
                end
                ST_CURVE:
                begin
                    if (curve_done)
                    begin
                        lvl_reg   <= curve_level;
                        held_reg  <= curve_level;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg                <= 1'b1;
                        m_tdata_reg                 <= lvl_reg;
                        m_tuser_reg[USER_RISE]      <= rise_reg;
                        m_tuser_reg[USER_CURVE_END] <= last_reg && last_sub;
                        m_tlast_reg                 <= last_sub;
                        if (last_sub)
                        begin
                            if (last_reg)
                            begin
                                // end of curve: state back to reset values
                                prev_reg  <= '0;
                                held_reg  <= '0;
                                rdone_reg <= 1'b0;
                                rseen_reg <= 1'b0;
                            end
                            else if (!rdone_reg)
                            begin
                                rseen_reg <= rseen_reg || rise_reg;
                                rdone_reg <= dset_reg;
                                prev_reg  <= t_reg;
                            end
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 4'd1;
                            num_reg   <= num_reg + {{6{step_reg[25]}}, step_reg};
                            state_reg <= ST_EVAL;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: design/hrc_checker.sv
// port-level checks for the hermite rise curve generator, bound to the top level
// depends on hrc_pkg for field positions

module hrc_checker import hrc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [LEVEL_W-1:0] m_tdata,
    input logic [USER_W-1:0]  m_tuser,
    input logic               m_tlast
);

    // a waiting result beat holds its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // curve end only on the last result of a frame
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[USER_CURVE_END] |-> m_tlast)
        else $error("curve end without last substep");

    // one frame at a time: busy right after a frame beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second frame taken while busy");

endmodule

bind hermite_rise_curve_generator_core hrc_checker u_hrc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: verif/hermite_rise_curve_generator_core_tb.sv
// self-checking testbench for hermite_rise_curve_generator_core: directed frames, then random curves
// results are predicted in-bench from the fixed-point curve arithmetic; needs design/hrc_pkg.sv

module hermite_rise_curve_generator_core_tb;
    import hrc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUBSTEP_CAP   = 8;
    localparam int RANDOM_FRAMES = 280;
    localparam int DRAIN_CYCLES  = 300;
    localparam int CYCLE_LIMIT   = 1200000;
    localparam int PRINT_CAP     = 40;

    // register indexes that hold nothing
    localparam logic [ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    // directed table
    typedef enum logic [1:0] {ROW_WRITE, ROW_FRAME, ROW_FRAME_KNOWN} row_kind_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [ADDR_W-1:0]  addr;
        logic [CFG_W-1:0]   value;   // register data or frame time
        logic               fin;
        logic [LEVEL_W-1:0] level;   // typed level on known rows
    } plan_row_t;

    localparam int PLAN_ROWS   = 39;
    localparam int PLAN_FRAMES = 20;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // straight out of reset: zero amplitude, one sample per frame
        '{ROW_FRAME_KNOWN, CFG_AMPLITUDE,     24'h000000, 1'b0, 24'h000000},
        '{ROW_FRAME_KNOWN, CFG_AMPLITUDE,     24'h000800, 1'b1, 24'h000000},
        // full amplitude, rise from frame 2.5 to 5.5, eight samples
        '{ROW_WRITE,       CFG_AMPLITUDE,     24'h00FFFF, 1'b0, 24'h000000},
        '{ROW_WRITE,       CFG_MIDPOINT_TIME, 24'h000400, 1'b0, 24'h000000},
        '{ROW_WRITE,       CFG_SPREAD,        24'h000100, 1'b0, 24'h000000},
        '{ROW_WRITE,       CFG_START_TANGENT, 24'h000000, 1'b0, 24'h000000},
        '{ROW_WRITE,       CFG_END_TANGENT,   24'h000000, 1'b0, 24'h000000},
        '{ROW_WRITE,       CFG_SUBSTEPS,      24'h000008, 1'b0, 24'h000000},
        '{ROW_WRITE,       CFG_SPARE_LO,      24'hFFFFFF, 1'b0, 24'h000000},
        '{ROW_WRITE,       CFG_SPARE_HI,      24'hFFFFFF, 1'b0, 24'h000000},
        '{ROW_FRAME_KNOWN, CFG_AMPLITUDE,     24'h000100, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h000300, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h000400, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h000500, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h000600, 1'b0, 24'h000000},
        // rise finished: plateau even with time going back
        '{ROW_FRAME_KNOWN, CFG_AMPLITUDE,     24'h000200, 1'b1, 24'h0FFFF0},
        // time going backward in the middle of the rise
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h000500, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h000300, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h000580, 1'b1, 24'h000000},
        // tangent extremes, both ways round
        '{ROW_WRITE,       CFG_START_TANGENT, 24'h007FFF, 1'b0, 24'h000000},
        '{ROW_WRITE,       CFG_END_TANGENT,   24'h008000, 1'b0, 24'h000000},
        '{ROW_WRITE,       CFG_SUBSTEPS,      24'h000003, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h000300, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h000400, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h000500, 1'b1, 24'h000000},
        '{ROW_WRITE,       CFG_START_TANGENT, 24'h008000, 1'b0, 24'h000000},
        '{ROW_WRITE,       CFG_END_TANGENT,   24'h007FFF, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h000380, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h0004C0, 1'b1, 24'h000000},
        // widest spread, latest midpoint, zero substeps
        '{ROW_WRITE,       CFG_SPREAD,        24'h00FFFF, 1'b0, 24'h000000},
        '{ROW_WRITE,       CFG_MIDPOINT_TIME, 24'hFFFFFF, 1'b0, 24'h000000},
        '{ROW_WRITE,       CFG_SUBSTEPS,      24'h000000, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'hFFFFFF, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h000000, 1'b1, 24'h000000},
        // zero spread, substeps over the cap
        '{ROW_WRITE,       CFG_SPREAD,        24'h000000, 1'b0, 24'h000000},
        '{ROW_WRITE,       CFG_SUBSTEPS,      24'h00000F, 1'b0, 24'h000000},
        '{ROW_WRITE,       CFG_MIDPOINT_TIME, 24'h001000, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h000FFF, 1'b0, 24'h000000},
        '{ROW_FRAME,       CFG_AMPLITUDE,     24'h001001, 1'b1, 24'h000000}
    };

    // one predicted result beat
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               rise;
        logic               last_sub;
        logic               curve_end;
    } curve_sample_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [ADDR_W-1:0]   cfg_addr = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TIME_W-1:0]   s_tdata = '0;   // [23:0] frame_time
    logic                s_tlast = 1'b0; // last_frame
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [LEVEL_W-1:0]  m_tdata;        // [23:0] level
    logic [USER_W-1:0]   m_tuser;        // [0] rise_frame, [1] curve_end
    logic                m_tlast;        // last_substep

    // register shadows
    logic        [AMP_W-1:0]  amp_reg = '0;
    logic        [TIME_W-1:0] mid_reg = '0;
    logic        [SPR_W-1:0]  spr_reg = 16'd256;
    logic signed [TAN_W-1:0]  st_reg  = '0;
    logic signed [TAN_W-1:0]  et_reg  = '0;
    logic        [SUB_W-1:0]  subs_reg = 4'd1;

    // curve state
    logic [TIME_W-1:0] prev_time = '0;
    longint            held_level = 0;
    logic              rise_done = 1'b0;
    logic              rise_seen = 1'b0;

    curve_sample_t awaited_samples [$];
    curve_sample_t head_sample;

    int  mismatches = 0;
    int  frames_sent = 0;
    int  results_checked = 0;
    int  settings_used = 0;
    int  cycle_count = 0;
    int  ready_hold = 0;
    logic quiet_spell = 1'b0;

    hermite_rise_curve_generator_core #(
        .MAX_SUBSTEPS (SUBSTEP_CAP)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still due", cycle_count,
                     awaited_samples.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
    endtask

    // curve value for a position q in Q0.16, saturated to 24 bit
    function automatic longint rise_shape(input longint q);
        longint s2, m, f, a, st, et;
        a  = amp_reg;
        st = st_reg;
        et = et_reg;
        s2 = (q * q) >>> 16;
        m  = q - 65536;
        f  = s2 * (196608 - 2 * q) * 4096 + s2 * m * et + ((q * m * m) >>> 16) * st;
        f  = f >>> 16;
        f  = (f * a) >>> 24;
        if (f > 8388607)
            f = 8388607;
        else if (f < -8388608)
            f = -8388608;
        return f;
    endfunction

    // work out the beats one frame causes and queue them
    task automatic advance_curve(input logic [TIME_W-1:0] ft, input logic fin,
                                 input logic typed, input logic [LEVEL_W-1:0] typed_level);
        longint t, prev, s, sp, d, num, plateau, mid, a;
        longint lv [SUBSTEP_CAP];
        logic rise;
        int k;
        curve_sample_t smp;
        t    = ft;
        prev = prev_time;
        mid  = mid_reg;
        a    = amp_reg;
        s    = subs_reg;
        sp   = spr_reg;
        if (s < 1)
            s = 1;
        if (s > SUBSTEP_CAP)
            s = SUBSTEP_CAP;
        if (sp == 0)
            sp = 1;
        plateau = a * 16;
        d    = 6 * sp * s;
        num  = 0;
        rise = 1'b0;

        // sample at k/S of the way from the previous frame time
        for (k = 1; k <= s; k++)
        begin
            if (rise_done)
                lv[k-1] = plateau;
            else
            begin
                num = 2 * (prev * s + (t - prev) * k - mid * s) + 3 * sp * s;
                if (num > d)
                    held_level = plateau;
                else if (num > 0)
                    held_level = rise_shape((num * 65536) / d);
                lv[k-1] = held_level;
            end
        end

        if (!rise_done)
        begin
            if (!rise_seen && num > 0)
            begin
                rise_seen = 1'b1;
                rise      = 1'b1;
            end
            if (num >= d)
                rise_done = 1'b1;
            prev_time = ft;
        end

        for (k = 0; k < s; k++)
        begin
            smp.level     = typed ? typed_level : lv[k][LEVEL_W-1:0];
            smp.rise      = rise;
            smp.last_sub  = (k == s - 1);
            smp.curve_end = fin && (k == s - 1);
            awaited_samples.push_back(smp);
        end

        // end of curve: back to the reset state, registers kept
        if (fin)
        begin
            prev_time  = '0;
            held_level = 0;
            rise_done  = 1'b0;
            rise_seen  = 1'b0;
        end
    endtask

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic int pick_gap();
        if (quiet_spell)
            return 0;
        if ($urandom_range(0, 99) < 50)
            return 0;
        return pick_pause();
    endfunction

    // stop offering frames and wait for every due beat
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_samples.size() != 0);
    endtask

    task automatic load_register(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (addr)
            CFG_AMPLITUDE:     amp_reg  = value[AMP_W-1:0];
            CFG_MIDPOINT_TIME: mid_reg  = value[TIME_W-1:0];
            CFG_SPREAD:        spr_reg  = value[SPR_W-1:0];
            CFG_START_TANGENT: st_reg   = value[TAN_W-1:0];
            CFG_END_TANGENT:   et_reg   = value[TAN_W-1:0];
            CFG_SUBSTEPS:      subs_reg = value[SUB_W-1:0];
            default: ;
        endcase
    endtask

    // offer one frame beat; valid stays up after acceptance until the next call or wait_idle
    task automatic offer_frame(input logic [TIME_W-1:0] ft, input logic fin,
                               input logic typed, input logic [LEVEL_W-1:0] typed_level);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ft;
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        advance_curve(ft, fin, typed, typed_level);
        frames_sent++;
    endtask

    // new random register setting, extremes now and then, junk above each narrower field
    task automatic retune_curve();
        logic [CFG_W-1:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: w[AMP_W-1:0] = '0;
            1: w[AMP_W-1:0] = '1;
            default: ;
        endcase
        load_register(CFG_AMPLITUDE, w);

        w = $urandom_range(24'h001000, 24'hFF0000);
        case ($urandom_range(0, 11))
            0: w = '0;
            1: w = '1;
            default: ;
        endcase
        load_register(CFG_MIDPOINT_TIME, w);

        w = $urandom;
        case ($urandom_range(0, 11))
            0: w[SPR_W-1:0] = '0;
            1: w[SPR_W-1:0] = 16'd1;
            2: w[SPR_W-1:0] = '1;
            3: ;
            default: w[SPR_W-1:0] = $urandom_range(16, 1536);
        endcase
        load_register(CFG_SPREAD, w);

        w = $urandom;
        case ($urandom_range(0, 7))
            0: w[TAN_W-1:0] = 16'h7FFF;
            1: w[TAN_W-1:0] = 16'h8000;
            2: w[TAN_W-1:0] = '0;
            default: ;
        endcase
        load_register(CFG_START_TANGENT, w);

        w = $urandom;
        case ($urandom_range(0, 7))
            0: w[TAN_W-1:0] = 16'h7FFF;
            1: w[TAN_W-1:0] = 16'h8000;
            2: w[TAN_W-1:0] = '0;
            default: ;
        endcase
        load_register(CFG_END_TANGENT, w);

        w = $urandom;
        case ($urandom_range(0, 9))
            0: w[SUB_W-1:0] = '0;
            1: w[SUB_W-1:0] = $urandom_range(9, 15);
            default: w[SUB_W-1:0] = $urandom_range(1, 8);
        endcase
        load_register(CFG_SUBSTEPS, w);
    endtask

    // one curve: mostly a clean walk through the rise, else noise or a broken walk
    task automatic run_curve();
        int sp, t, stop_at, step, n, kind, frames;
        logic fin;
        sp = (spr_reg == 0) ? 1 : int'(spr_reg);
        kind = $urandom_range(0, 19);
        if (kind >= 15 && kind <= 16)
        begin
            // random times, random ends
            frames = $urandom_range(1, 5);
            for (n = 0; n < frames; n++)
                offer_frame(TIME_W'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
        end
        else
        begin
            t       = int'(mid_reg) - 2 * sp - int'($urandom_range(0, sp));
            stop_at = int'(mid_reg) + 2 * sp;
            frames  = $urandom_range(3, 10);
            n       = 0;
            fin     = 1'b0;
            while (!fin)
            begin
                if (kind < 15)
                    fin = (t >= stop_at) || (n == 14);
                else
                    fin = (n == frames);
                // broken walks never close the curve
                offer_frame(t[TIME_W-1:0], fin && (kind < 15), 1'b0, '0);
                step = $urandom_range(sp / 4 + 1, sp + 1);
                if (kind >= 17 && $urandom_range(0, 2) == 0)
                    t = t - step;
                else
                    t = t + step;
                n++;
            end
        end
    endtask

    // result sink back-pressure
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (quiet_spell || !m_tready)
        begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 12);
        end
        else
        begin
            m_tready   <= 1'b0;
            ready_hold <= pick_pause() - 1;
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            results_checked++;
            if (awaited_samples.size() == 0)
                report_mismatch("unexpected beat, level", m_tdata, 0);
            else
            begin
                head_sample = awaited_samples.pop_front();
                if (m_tdata !== head_sample.level)
                    report_mismatch("level", m_tdata, head_sample.level);
                if (m_tuser[USER_RISE] !== head_sample.rise)
                    report_mismatch("rise_frame", m_tuser[USER_RISE], head_sample.rise);
                if (m_tlast !== head_sample.last_sub)
                    report_mismatch("last_substep", m_tlast, head_sample.last_sub);
                if (m_tuser[USER_CURVE_END] !== head_sample.curve_end)
                    report_mismatch("curve_end", m_tuser[USER_CURVE_END],
                                    head_sample.curve_end);
            end
        end
    end

    // stimulus
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (PLAN[i].kind == ROW_WRITE)
                load_register(PLAN[i].addr, PLAN[i].value);
            else
                offer_frame(PLAN[i].value[TIME_W-1:0], PLAN[i].fin,
                            PLAN[i].kind == ROW_FRAME_KNOWN, PLAN[i].level);
        end

        // random curves, each under a fresh setting
        while (frames_sent < PLAN_FRAMES + RANDOM_FRAMES)
        begin
            quiet_spell <= ($urandom_range(0, 4) == 0);
            retune_curve();
            settings_used++;
            run_curve();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d frames over %0d random settings plus the directed table",
                 frames_sent, settings_used);
        $display("%0d result beats checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
